FILE: rtl/core/ffha_pkg.sv
package ffha_pkg;

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_FULL  = 2'd1,
		ST_FREED = 2'd2,
		ST_NULL  = 2'd3
	} status_t;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] request_bytes;
		logic [11:0] block_index;
		logic        null_pointer;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] granted_index;
		logic [12:0] free_space_nodes;
		logic [11:0] free_block_total;
		logic [12:0] live_block_total;
		logic [31:0] failure_total;
		logic        heap_full;
	} rsp_t;

endpackage

FILE: rtl/core/ffha_mem.sv
module ffha_mem #(
	parameter int AW = 12,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// channel  | ports                      | handshake
// request  | start, busy, req           | taken when start && !busy
// result   | done, rsp                  | one-cycle strobe on done
// steps from acceptance to the result:
// an allocate walks the free list (read, wait, check per entry), then carves or reports full
// a free reads and clamps the block length, walks the list, then links and merges
// a null free goes straight to the result; each list step waits for the registered read
// reset sets control and counters to their initial values; memory entry 0 is written by the init state
// the receiver cannot stall: results are never held
module first_fit_heap_allocator_unit #(
	parameter int HEAP_NODES   = 4096,
	parameter int NODE_BYTES   = 4,
	parameter int HEADER_BYTES = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ffha_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output ffha_pkg::rsp_t  rsp
);

	localparam int AW = (HEAP_NODES > 2) ? $clog2(HEAP_NODES) : 1;
	localparam logic [15:0] END_MARK = 16'hFFFF;
	localparam int RSH = 21;
	localparam logic [21:0] RECIP = 22'((2**RSH + NODE_BYTES - 1) / NODE_BYTES);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_AEX,
		S_ACARVE, S_FLRD, S_FLWAIT, S_FLFIX, S_FRD, S_FWAIT, S_FCHK,
		S_FINS, S_FNRD, S_FNWAIT, S_FNCHK, S_FTAIL, S_DONE
	} state_t;

	state_t state_q;
	logic [15:0] len_rd, nxt_rd;
	logic len_we, nxt_we;
	logic [AW-1:0] len_wa, nxt_wa, rd_a;
	logic [15:0] len_wd, nxt_wd;

	ffha_mem #(.AW(AW), .DW(16)) u_len (
		.clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
		.raddr(rd_a), .rdata(len_rd));
	ffha_mem #(.AW(AW), .DW(16)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(rd_a), .rdata(nxt_rd));

	logic [15:0] head_q, cur_q, prev_q, f_q, blk_q, nx_q;
	logic        prev_head_q;
	logic        blk_in_q;
	logic [17:0] need_q;
	logic [16:0] flen_q, blen_q;
	logic [16:0] steps_q;
	logic [12:0] fnl_q;
	logic [11:0] fbc_q;
	logic [12:0] live_q;
	logic [31:0] fail_q;
	logic        full_q;
	logic [1:0]  st_q;
	logic [11:0] gr_q;
	logic [15:0] rd_at_q;
	logic [15:0] wa_q, wd_q;
	logic        lw_q, nw_q;
	logic [15:0] nwa_q, nwd_q;

	assign rd_a = rd_at_q[AW-1:0];
	assign len_we = lw_q;
	assign len_wa = wa_q[AW-1:0];
	assign len_wd = wd_q;
	assign nxt_we = nw_q;
	assign nxt_wa = nwa_q[AW-1:0];
	assign nxt_wd = nwd_q;

	assign busy = (state_q != S_IDLE);

	logic [17:0] sum_w;
	assign sum_w = {2'b0, req.request_bytes} + 18'(HEADER_BYTES + NODE_BYTES - 1);

	// division by the node size as a reciprocal multiply, exact for sums below 2^17
	logic [39:0] prod_w;
	logic [17:0] need_w;
	assign prod_w = {22'b0, sum_w} * {18'b0, RECIP};
	assign need_w = prod_w[RSH+17:RSH];

	logic cur_ok;
	assign cur_ok = (cur_q < 16'(HEAP_NODES)) && (steps_q < 17'(HEAP_NODES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			head_q <= '0; fnl_q <= 13'(HEAP_NODES); fbc_q <= 12'd1;
			live_q <= '0; fail_q <= '0; full_q <= 1'b0;
			done <= 1'b0; lw_q <= 1'b0; nw_q <= 1'b0;
			wa_q <= '0; wd_q <= '0; nwa_q <= '0; nwd_q <= '0; rd_at_q <= '0;
		end else begin
			done <= 1'b0;
			lw_q <= 1'b0;
			nw_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					lw_q <= 1'b1; wa_q <= '0; wd_q <= 16'(HEAP_NODES);
					nw_q <= 1'b1; nwa_q <= '0; nwd_q <= END_MARK;
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						prev_head_q <= 1'b1; cur_q <= head_q; steps_q <= '0;
						gr_q <= '0;
						if (req.req_type == ffha_pkg::REQ_ALLOC) begin
							need_q <= need_w;
							state_q <= S_ARD;
						end else if (req.null_pointer ||
							({4'b0, req.block_index} >= 16'(HEAP_NODES))) begin
							st_q <= ffha_pkg::ST_NULL;
							state_q <= S_DONE;
						end else begin
							f_q <= {4'b0, req.block_index};
							rd_at_q <= {4'b0, req.block_index};
							state_q <= S_FLRD;
						end
					end
				end
				S_ARD: begin
					if (need_q == 18'd0) need_q <= 18'd1;
					if (cur_ok) begin
						rd_at_q <= cur_q; state_q <= S_AWAIT;
					end else begin
						fail_q <= fail_q + 32'd1; full_q <= 1'b1;
						st_q <= ffha_pkg::ST_FULL; state_q <= S_DONE;
					end
				end
				S_AWAIT: state_q <= S_ACHK;
				S_ACHK: begin
					if ({2'b0, len_rd} < need_q) begin
						prev_head_q <= 1'b0; prev_q <= cur_q; cur_q <= nxt_rd;
						steps_q <= steps_q + 17'd1; state_q <= S_ARD;
					end else begin
						if (live_q != 13'h1FFF) live_q <= live_q + 13'd1;
						fnl_q <= ({5'b0, fnl_q} > need_q) ? fnl_q - 13'(need_q) : '0;
						st_q <= ffha_pkg::ST_ALLOC;
						if ({2'b0, len_rd} == need_q) begin
							if (prev_head_q) head_q <= nxt_rd;
							else begin
								nw_q <= 1'b1; nwa_q <= prev_q; nwd_q <= nxt_rd;
							end
							if (fbc_q != 0) fbc_q <= fbc_q - 12'd1;
							gr_q <= cur_q[11:0];
							lw_q <= 1'b1; wa_q <= cur_q; wd_q <= len_rd;
							state_q <= S_DONE;
						end else begin
							lw_q <= 1'b1; wa_q <= cur_q; wd_q <= len_rd - 16'(need_q);
							blk_q <= cur_q + len_rd - 16'(need_q);
							blk_in_q <= ({1'b0, cur_q} + {1'b0, len_rd} - 17'(need_q))
								< 17'(HEAP_NODES);
							state_q <= S_ACARVE;
						end
					end
				end
				S_ACARVE: begin
					gr_q <= blk_q[11:0];
					if (blk_in_q) begin
						lw_q <= 1'b1; wa_q <= blk_q; wd_q <= 16'(need_q);
					end
					state_q <= S_DONE;
				end
				S_FLRD: state_q <= S_FLWAIT;
				S_FLWAIT: begin
					if (len_rd == 0) flen_q <= 17'd1;
					else flen_q <= {1'b0, len_rd};
					state_q <= S_FLFIX;
				end
				S_FLFIX: begin
					if ({1'b0, f_q} + flen_q > 17'(HEAP_NODES)) begin
						flen_q <= 17'(HEAP_NODES) - {1'b0, f_q};
						wd_q <= 16'(HEAP_NODES) - f_q;
						fnl_q <= ({4'b0, fnl_q} + 17'(HEAP_NODES) - {1'b0, f_q}
							> 17'(HEAP_NODES)) ? 13'(HEAP_NODES)
							: 13'({4'b0, fnl_q} + 17'(HEAP_NODES) - {1'b0, f_q});
					end else begin
						wd_q <= flen_q[15:0];
						fnl_q <= ({4'b0, fnl_q} + flen_q > 17'(HEAP_NODES))
							? 13'(HEAP_NODES) : 13'({4'b0, fnl_q} + flen_q);
					end
					lw_q <= 1'b1; wa_q <= f_q;
					full_q <= 1'b0;
					if (live_q != 0) live_q <= live_q - 13'd1;
					st_q <= ffha_pkg::ST_FREED;
					state_q <= S_FRD;
				end
				S_FRD: begin
					if (cur_ok) begin
						rd_at_q <= cur_q; state_q <= S_FWAIT;
					end else begin
						nw_q <= 1'b1; nwa_q <= f_q; nwd_q <= END_MARK;
						if (prev_head_q) head_q <= f_q;
						if (fbc_q != 12'hFFF) fbc_q <= fbc_q + 12'd1;
						state_q <= prev_head_q ? S_DONE : S_FTAIL;
					end
				end
				S_FTAIL: begin
					nw_q <= 1'b1; nwa_q <= prev_q; nwd_q <= f_q;
					state_q <= S_DONE;
				end
				S_FWAIT: state_q <= S_FCHK;
				S_FCHK: begin
					if ({1'b0, cur_q} + {1'b0, len_rd} < {1'b0, f_q}) begin
						prev_head_q <= 1'b0; prev_q <= cur_q; cur_q <= nxt_rd;
						steps_q <= steps_q + 17'd1; state_q <= S_FRD;
					end else if ({1'b0, cur_q} + {1'b0, len_rd} == {1'b0, f_q}) begin
						lw_q <= 1'b1; wa_q <= cur_q; wd_q <= len_rd + flen_q[15:0];
						blk_q <= cur_q; blen_q <= {1'b0, len_rd + flen_q[15:0]};
						nx_q <= nxt_rd; state_q <= S_FNRD;
					end else begin
						nw_q <= 1'b1; nwa_q <= f_q; nwd_q <= cur_q;
						if (prev_head_q) head_q <= f_q;
						if (fbc_q != 12'hFFF) fbc_q <= fbc_q + 12'd1;
						blk_q <= f_q; blen_q <= flen_q; nx_q <= cur_q;
						state_q <= S_FINS;
					end
				end
				S_FINS: begin
					if (!prev_head_q) begin
						nw_q <= 1'b1; nwa_q <= prev_q; nwd_q <= f_q;
					end
					state_q <= S_FNRD;
				end
				S_FNRD: begin
					if (nx_q < 16'(HEAP_NODES) && ({1'b0, blk_q} + blen_q == {1'b0, nx_q})) begin
						rd_at_q <= nx_q; state_q <= S_FNWAIT;
					end else state_q <= S_DONE;
				end
				S_FNWAIT: state_q <= S_FNCHK;
				S_FNCHK: begin
					lw_q <= 1'b1; wa_q <= blk_q; wd_q <= blen_q[15:0] + len_rd;
					nw_q <= 1'b1; nwa_q <= blk_q; nwd_q <= nxt_rd;
					if (fbc_q != 0) fbc_q <= fbc_q - 12'd1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					rsp.status <= st_q;
					rsp.granted_index <= (st_q == ffha_pkg::ST_ALLOC) ? gr_q : '0;
					rsp.free_space_nodes <= fnl_q;
					rsp.free_block_total <= fbc_q;
					rsp.live_block_total <= live_q;
					rsp.failure_total <= fail_q;
					rsp.heap_full <= full_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/ffha_checker.sv
module ffha_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input ffha_pkg::rsp_t rsp
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");
	a_full_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ffha_pkg::ST_FULL) |-> rsp.heap_full)
		else $error("full result without flag");
	a_freed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ffha_pkg::ST_FREED) |-> !rsp.heap_full)
		else $error("free left flag set");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp));

FILE: tb/sv/first_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_tb;

	localparam int HEAP_NODES   = 4096;
	localparam int NODE_BYTES   = 4;
	localparam int HEADER_BYTES = 2;
	localparam int unsigned HEAD_LINK = 32'hFFFF_FFFF;
	localparam int N_RANDOM     = 1520;
	localparam longint CYCLE_LIMIT = 100_000_000;

	class heap_scoreboard;
		bit [15:0] blen [HEAP_NODES];
		bit [15:0] link [HEAP_NODES];
		int unsigned head, free_nodes, free_blocks, live, fails;
		bit full;
		ffha_pkg::rsp_t pending [$];
		int errors;

		function new();
			blen[0] = 16'(HEAP_NODES);
			link[0] = 16'hFFFF;
			head = 0;
			free_nodes = HEAP_NODES;
			free_blocks = 1;
			live = 0;
			fails = 0;
			full = 0;
			errors = 0;
		endfunction

		function void set_link(int unsigned prev, int unsigned target);
			if (prev == HEAD_LINK) begin
				head = target;
			end else if (prev < HEAP_NODES) begin
				link[prev] = target[15:0];
			end
		endfunction

		function void blocks_up();
			if (free_blocks < 4095) begin
				free_blocks++;
			end
		endfunction

		function void blocks_down();
			if (free_blocks > 0) begin
				free_blocks--;
			end
		endfunction

		function bit carve(int unsigned bytes, output int unsigned granted);
			int unsigned need, prev, cur, steps, len;
			need = (HEADER_BYTES + bytes + NODE_BYTES - 1) / NODE_BYTES;
			prev = HEAD_LINK;
			cur = head;
			steps = 0;
			granted = 0;
			if (need == 0) begin
				need = 1;
			end
			while (cur < HEAP_NODES && steps < HEAP_NODES) begin
				len = blen[cur];
				if (len < need) begin
					prev = cur;
					cur = link[cur];
					steps++;
					continue;
				end
				if (live < 8191) begin
					live++;
				end
				if (len == need) begin
					set_link(prev, link[cur]);
					blocks_down();
					granted = cur;
				end else begin
					blen[cur] = 16'(len - need);
					granted = cur + len - need;
				end
				free_nodes = (free_nodes > need) ? free_nodes - need : 0;
				if (granted < HEAP_NODES) begin
					blen[granted] = 16'(need);
				end
				return 1;
			end
			fails++;
			full = 1;
			return 0;
		endfunction

		function void release_block(int unsigned f);
			int unsigned len, prev, cur, steps, stop, blk, nx;
			len = blen[f];
			prev = HEAD_LINK;
			cur = head;
			steps = 0;
			if (len == 0) begin
				len = 1;
			end
			if (f + len > HEAP_NODES) begin
				len = HEAP_NODES - f;
			end
			blen[f] = 16'(len);
			full = 0;
			if (live > 0) begin
				live--;
			end
			free_nodes += len;
			if (free_nodes > HEAP_NODES) begin
				free_nodes = HEAP_NODES;
			end
			while (cur < HEAP_NODES && steps < HEAP_NODES) begin
				stop = cur + blen[cur];
				if (stop < f) begin
					prev = cur;
					cur = link[cur];
					steps++;
					continue;
				end
				if (stop == f) begin
					blen[cur] = 16'(blen[cur] + len);
					blk = cur;
				end else begin
					link[f] = 16'(cur);
					set_link(prev, f);
					blocks_up();
					blk = f;
				end
				nx = link[blk];
				if (nx < HEAP_NODES && blk + blen[blk] == nx) begin
					blen[blk] = 16'(blen[blk] + blen[nx]);
					link[blk] = link[nx];
					blocks_down();
				end
				return;
			end
			link[f] = 16'hFFFF;
			set_link(prev, f);
			blocks_up();
		endfunction

		function ffha_pkg::rsp_t note(ffha_pkg::req_t r);
			ffha_pkg::rsp_t e;
			int unsigned g;
			e = '0;
			if (r.req_type == ffha_pkg::REQ_ALLOC) begin
				if (carve(32'(r.request_bytes), g)) begin
					e.status = ffha_pkg::ST_ALLOC;
					e.granted_index = g[11:0];
				end else begin
					e.status = ffha_pkg::ST_FULL;
				end
			end else if (r.null_pointer || r.block_index >= HEAP_NODES) begin
				e.status = ffha_pkg::ST_NULL;
			end else begin
				release_block(32'(r.block_index));
				e.status = ffha_pkg::ST_FREED;
			end
			e.free_space_nodes = free_nodes[12:0];
			e.free_block_total = free_blocks[11:0];
			e.live_block_total = live[12:0];
			e.failure_total = fails;
			e.heap_full = full;
			pending.push_back(e);
			return e;
		endfunction

		function void check(ffha_pkg::rsp_t got);
			ffha_pkg::rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result %p", got);
				end
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10) begin
					$display("result mismatch: expected %p, actual %p", e, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	ffha_pkg::req_t req;
	logic busy;
	logic done;
	ffha_pkg::rsp_t rsp;

	heap_scoreboard sb;
	int unsigned live_blocks [$];
	longint cycles;
	bit quiet;

	first_fit_heap_allocator_unit #(
		.HEAP_NODES(HEAP_NODES),
		.NODE_BYTES(NODE_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("first_fit_heap_allocator_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check(rsp);
		end
	end

	task automatic issue(input ffha_pkg::req_t r);
		ffha_pkg::rsp_t e;
		int gap;
		int pos;
		gap = 0;
		pos = 0;
		if (!quiet && $urandom_range(99) < 25) begin
			gap = $urandom_range(1, 6);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		e = sb.note(r);
		if (e.status == ffha_pkg::ST_ALLOC) begin
			live_blocks.push_back(32'(e.granted_index));
		end else if (e.status == ffha_pkg::ST_FREED) begin
			foreach (live_blocks[i]) begin
				if (live_blocks[i] == 32'(r.block_index)) begin
					pos = i;
				end
			end
			live_blocks.delete(pos);
		end
	endtask

	task automatic alloc(input int unsigned bytes);
		ffha_pkg::req_t r;
		r = '0;
		r.req_type = ffha_pkg::REQ_ALLOC;
		r.request_bytes = bytes[15:0];
		r.block_index = 12'($urandom_range(4095));
		r.null_pointer = 1'($urandom_range(1));
		issue(r);
	endtask

	task automatic free_live(input int unsigned k);
		ffha_pkg::req_t r;
		r = '0;
		r.req_type = ffha_pkg::REQ_FREE;
		r.request_bytes = 16'($urandom_range(65535));
		r.block_index = live_blocks[k][11:0];
		r.null_pointer = 1'b0;
		issue(r);
	endtask

	task automatic free_null(input int unsigned idx);
		ffha_pkg::req_t r;
		r = '0;
		r.req_type = ffha_pkg::REQ_FREE;
		r.request_bytes = 16'($urandom_range(65535));
		r.block_index = idx[11:0];
		r.null_pointer = 1'b1;
		issue(r);
	endtask

	initial begin
		int pick;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cycles = 0;
		quiet = 0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole heap in one exact fit, then full
		alloc(HEAP_NODES * NODE_BYTES - HEADER_BYTES);
		alloc(0);
		alloc(65535);
		free_live(0);
		free_null(0);
		free_null(4095);
		// zero-size, carve from end, and merges on both sides
		alloc(0);
		alloc(1);
		alloc(2);
		alloc(3);
		alloc(100);
		free_live(0);
		free_live(1);
		free_live(1);
		alloc(6);
		alloc(2);
		free_live(live_blocks.size() - 1);
		free_live(0);
		alloc(16000);
		alloc(65535);
		free_live(0);
		while (live_blocks.size() > 0) begin
			free_live(0);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 600 && i < 900);
			pick = $urandom_range(99);
			if (pick < 8) begin
				free_null($urandom_range(4095));
			end else if (pick < 50 && live_blocks.size() > 0) begin
				free_live($urandom_range(live_blocks.size() - 1));
			end else begin
				n = $urandom_range(99);
				if (n < 70) begin
					alloc($urandom_range(60));
				end else if (n < 92) begin
					alloc($urandom_range(1000));
				end else begin
					alloc($urandom_range(65535));
				end
			end
		end
		start <= 1'b0;

		while (sb.pending.size() > 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("first_fit_heap_allocator_unit: match");
		end else begin
			$display("first_fit_heap_allocator_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_mem.sv
rtl/core/first_fit_heap_allocator_unit.sv
rtl/core/ffha_checker.sv
tb/sv/first_fit_heap_allocator_unit_tb.sv
